>>> hw/rtl/oemd_pkg.sv
// Shared types, register codes and constants of the obstacle escape motor drive.
package oemd_pkg;

	localparam logic [11:0] MID_CODE = 12'd2047;
	localparam logic [11:0] MAX_CODE = 12'd4095;
	// Upper clamp bound of a drive value, signed fixed point with 8 fraction bits (Q17.8)
	localparam logic signed [25:0] CLAMP_HI_Q88 = 26'sd1048320;

	localparam logic [11:0] RST_CURRENT_THRESHOLD = 12'd2140;
	localparam logic [10:0] RST_DRIVE_OFFSET      = 11'd400;
	localparam logic [7:0]  RST_STEER_GAIN        = 8'd40;
	localparam logic [7:0]  RST_OVER_STEPS        = 8'd2;
	localparam logic [7:0]  RST_REVERSE_STEPS     = 8'd5;
	localparam logic [7:0]  RST_TURN_BASE_STEPS   = 8'd15;
	localparam logic [7:0]  RST_SETTLE_STEPS      = 8'd10;

	localparam logic [7:0]  COUNT_MAX = 8'd255;

	typedef enum logic [2:0] {
		REG_CURRENT_THRESHOLD = 3'd0,
		REG_DRIVE_OFFSET      = 3'd1,
		REG_STEER_GAIN        = 3'd2,
		REG_OVER_STEPS        = 3'd3,
		REG_REVERSE_STEPS     = 3'd4,
		REG_TURN_BASE_STEPS   = 3'd5,
		REG_SETTLE_STEPS      = 3'd6
	} cfg_index_t;

	typedef enum logic [1:0] {
		PHASE_STEER   = 2'd0,
		PHASE_REVERSE = 2'd1,
		PHASE_TURN    = 2'd2
	} phase_t;

	typedef struct packed {
		logic [11:0] current_threshold;
		logic [10:0] drive_offset;
		logic [7:0]  steer_gain;
		logic [7:0]  over_threshold_steps;
		logic [7:0]  reverse_steps;
		logic [7:0]  turn_base_steps;
		logic [7:0]  settle_steps;
	} oemd_cfg_t;

endpackage

>>> hw/rtl/oemd_sample_if.sv
// Input channel of the motor drive: one control tick per beat.
interface oemd_sample_if;
	logic               valid;
	logic               ready;
	logic [11:0]        motor_current;
	logic signed [15:0] steer_value;
	logic [3:0]         turn_extra;

	modport source(output valid, motor_current, steer_value, turn_extra, input ready);
	modport sink(input valid, motor_current, steer_value, turn_extra, output ready);
endinterface

>>> hw/rtl/oemd_result_if.sv
// Output channel of the motor drive: one pair of drive codes per beat.
interface oemd_result_if;
	logic        valid;
	logic        ready;
	logic [11:0] left_drive;
	logic [11:0] right_drive;
	logic [1:0]  phase;
	logic        drive_clamped;

	modport source(output valid, left_drive, right_drive, phase, drive_clamped, input ready);
	modport sink(input valid, left_drive, right_drive, phase, drive_clamped, output ready);
endinterface

>>> hw/rtl/oemd_steer.sv
// Steering drive: gain times steering around midscale plus offset, clamped to 12 bits.
module oemd_steer (
	input  oemd_pkg::oemd_cfg_t cfg,
	input  logic signed [15:0]  steer_value,
	output logic [11:0]         left_drive,
	output logic [11:0]         right_drive,
	output logic                clamped
);
	import oemd_pkg::*;

	logic [11:0]        mid_plus;
	logic signed [25:0] base_q88;
	logic signed [24:0] corr;
	logic signed [25:0] corr_x;
	logic signed [25:0] v_left;
	logic signed [25:0] v_right;
	logic               clamp_l;
	logic               clamp_r;

	assign mid_plus = MID_CODE + {1'b0, cfg.drive_offset};
	assign base_q88 = $signed({6'd0, mid_plus, 8'd0});
	assign corr     = $signed({1'b0, cfg.steer_gain}) * steer_value;
	assign corr_x   = {corr[24], corr};
	assign v_left   = base_q88 - corr_x;
	assign v_right  = base_q88 + corr_x;

	always_comb begin
		clamp_l = 1'b1;
		if (v_left <= 26'sd0) begin
			left_drive = 12'd0;
		end else if (v_left >= CLAMP_HI_Q88) begin
			left_drive = MAX_CODE;
		end else begin
			left_drive = v_left[19:8];
			clamp_l    = 1'b0;
		end
	end

	always_comb begin
		clamp_r = 1'b1;
		if (v_right <= 26'sd0) begin
			right_drive = 12'd0;
		end else if (v_right >= CLAMP_HI_Q88) begin
			right_drive = MAX_CODE;
		end else begin
			right_drive = v_right[19:8];
			clamp_r     = 1'b0;
		end
	end

	assign clamped = clamp_l | clamp_r;

endmodule

>>> hw/rtl/obstacle_escape_motor_drive_unit.sv
// Top level of the obstacle escape motor drive: tick register, escape sequencer, result register.
// Takes one control tick per clock while results are taken, and returns one drive result per
// tick. A tick goes into the input register on the beat that accepts it and moves on into the
// output register once that register is free; the steering multiply and clamp sit between
// those two registers. A stalled result holds the output register, and the input register
// still takes one further tick behind it. Configuration writes are registered; registers
// reset to threshold 2140, offset 400, gain 40, over count 2, reverse 5, turn base 15 and
// settle 10, and the first nine ticks after reset do not look for an obstacle. Unknown
// register indexes are ignored.
module obstacle_escape_motor_drive_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [11:0] cfg_data,
	oemd_sample_if.sink   sample,
	oemd_result_if.source result
);
	import oemd_pkg::*;

	oemd_cfg_t cfg_q;

	logic               valid_s1;
	logic [11:0]        current_s1;
	logic signed [15:0] steer_s1;
	logic [3:0]         extra_s1;

	logic [7:0] over_count_q;
	logic [7:0] reverse_left_q;
	logic [7:0] turn_left_q;
	logic [7:0] settle_left_q;
	logic       turn_dir_q;

	logic [7:0] over_count_n;
	logic [7:0] reverse_left_n;
	logic [7:0] turn_left_n;
	logic [7:0] settle_left_n;
	logic       turn_dir_n;

	logic        out_valid_q;
	logic [11:0] left_q;
	logic [11:0] right_q;
	phase_t      phase_q;
	logic        clamped_q;

	logic        out_free;
	logic        fire_s1;
	logic [7:0]  settle_dec;
	logic [7:0]  over_inc;
	logic        detect;
	logic [7:0]  reverse_act;
	logic [8:0]  turn_sum;
	logic [7:0]  turn_load;
	logic [11:0] drive_lo;
	logic [11:0] drive_hi;
	logic [11:0] steer_left;
	logic [11:0] steer_right;
	logic        steer_clamped;
	logic [11:0] left_n;
	logic [11:0] right_n;
	phase_t      phase_n;
	logic        clamped_n;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.current_threshold    <= RST_CURRENT_THRESHOLD;
			cfg_q.drive_offset         <= RST_DRIVE_OFFSET;
			cfg_q.steer_gain           <= RST_STEER_GAIN;
			cfg_q.over_threshold_steps <= RST_OVER_STEPS;
			cfg_q.reverse_steps        <= RST_REVERSE_STEPS;
			cfg_q.turn_base_steps      <= RST_TURN_BASE_STEPS;
			cfg_q.settle_steps         <= RST_SETTLE_STEPS;
		end else if (cfg_we) begin
			case (cfg_index_t'(cfg_index))
				REG_CURRENT_THRESHOLD: cfg_q.current_threshold    <= cfg_data;
				REG_DRIVE_OFFSET:      cfg_q.drive_offset         <= cfg_data[10:0];
				REG_STEER_GAIN:        cfg_q.steer_gain           <= cfg_data[7:0];
				REG_OVER_STEPS:        cfg_q.over_threshold_steps <= cfg_data[7:0];
				REG_REVERSE_STEPS:     cfg_q.reverse_steps        <= cfg_data[7:0];
				REG_TURN_BASE_STEPS:   cfg_q.turn_base_steps      <= cfg_data[7:0];
				REG_SETTLE_STEPS:      cfg_q.settle_steps         <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Handshake: the input register moves on whenever the output register is free
	assign out_free     = !out_valid_q || result.ready;
	assign fire_s1      = valid_s1 && out_free;
	assign sample.ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.ready && sample.valid) begin
			current_s1 <= sample.motor_current;
			steer_s1   <= sample.steer_value;
			extra_s1   <= sample.turn_extra;
		end
	end

	oemd_steer u_steer (
		.cfg         (cfg_q),
		.steer_value (steer_s1),
		.left_drive  (steer_left),
		.right_drive (steer_right),
		.clamped     (steer_clamped)
	);

	// Escape sequencer: one tick of state update
	assign settle_dec  = (settle_left_q != 8'd0) ? settle_left_q - 8'd1 : 8'd0;
	assign detect      = (current_s1 > cfg_q.current_threshold) && (reverse_left_q == 8'd0) &&
	                     (turn_left_q == 8'd0) && (settle_dec == 8'd0);
	assign over_inc    = (over_count_q == COUNT_MAX) ? COUNT_MAX : over_count_q + 8'd1;
	assign reverse_act = (detect && (over_inc > cfg_q.over_threshold_steps)) ?
	                     cfg_q.reverse_steps : reverse_left_q;
	assign turn_sum    = {1'b0, cfg_q.turn_base_steps} + {5'd0, extra_s1};
	assign turn_load   = turn_sum[8] ? COUNT_MAX : turn_sum[7:0];
	assign drive_lo    = MID_CODE - {1'b0, cfg_q.drive_offset};
	assign drive_hi    = MID_CODE + {1'b0, cfg_q.drive_offset};

	always_comb begin
		over_count_n   = detect ? over_inc : 8'd0;
		reverse_left_n = reverse_act;
		turn_left_n    = turn_left_q;
		settle_left_n  = settle_dec;
		turn_dir_n     = turn_dir_q;
		left_n         = steer_left;
		right_n        = steer_right;
		phase_n        = PHASE_STEER;
		clamped_n      = steer_clamped;
		if (reverse_act != 8'd0) begin
			left_n         = drive_lo;
			right_n        = drive_lo;
			phase_n        = PHASE_REVERSE;
			clamped_n      = 1'b0;
			reverse_left_n = reverse_act - 8'd1;
			// turn is armed as the count passes through one
			if (reverse_act == 8'd2) begin
				turn_left_n = turn_load;
			end
		end else if (turn_left_q != 8'd0) begin
			left_n      = turn_dir_q ? drive_lo : drive_hi;
			right_n     = turn_dir_q ? drive_hi : drive_lo;
			phase_n     = PHASE_TURN;
			clamped_n   = 1'b0;
			turn_left_n = turn_left_q - 8'd1;
			if (turn_left_q == 8'd1) begin
				settle_left_n = cfg_q.settle_steps;
				turn_dir_n    = !turn_dir_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			over_count_q   <= 8'd0;
			reverse_left_q <= 8'd0;
			turn_left_q    <= 8'd0;
			settle_left_q  <= RST_SETTLE_STEPS;
			turn_dir_q     <= 1'b0;
		end else if (fire_s1) begin
			over_count_q   <= over_count_n;
			reverse_left_q <= reverse_left_n;
			turn_left_q    <= turn_left_n;
			settle_left_q  <= settle_left_n;
			turn_dir_q     <= turn_dir_n;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			left_q    <= left_n;
			right_q   <= right_n;
			phase_q   <= phase_n;
			clamped_q <= clamped_n;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.left_drive    = left_q;
	assign result.right_drive   = right_q;
	assign result.phase         = phase_q;
	assign result.drive_clamped = clamped_q;

	// Clamp flag belongs to steering beats only
	a_clamp_steer_only: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && (result.phase != PHASE_STEER)) |-> !result.drive_clamped)
		else $error("clamp flag set outside steering phase");

	// Reversing drives both motors alike
	a_reverse_equal: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && (result.phase == PHASE_REVERSE)) |->
		(result.left_drive == result.right_drive))
		else $error("reverse beat with unequal drives");

	// No counting of over-current ticks while the settle count runs
	a_settle_no_count: assert property (@(posedge clk) disable iff (!arst_n)
		(settle_left_q != 8'd0) |-> (over_count_q == 8'd0))
		else $error("over-current count running during settle");

	// State only moves when a tick leaves the input register
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!fire_s1 |=> ($stable(reverse_left_q) && $stable(turn_left_q) && $stable(turn_dir_q)))
		else $error("escape state changed without a tick");

	// Turn direction flips only on a turning beat
	a_dir_on_turn: assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && (turn_left_q == 8'd0)) |=> $stable(turn_dir_q))
		else $error("turn direction changed outside a turn");

endmodule
